// File: rtl/core/did_pkg.sv
// shared types, codes and helpers for the interrupt dispatch block
package did_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_CHECK = 2'd0,
    FUNC_POST  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LEVEL_CHECK = 2'd0,
    CFG_FRAME_HOLD  = 2'd1,
    CFG_FRAME_PRIO  = 2'd2,
    CFG_PUSH_PAGE   = 2'd3
  } cfg_idx_t;

  localparam int unsigned FRAME_BIT   = 12;
  localparam int unsigned DMA_BIT     = 14;
  localparam logic [8:0]  TABLE_UNSET = 9'h1FF;
  localparam logic [4:0]  VECTOR_BASE = 5'd16;

  // configuration bits
  typedef struct packed {
    logic level_check_enable;
    logic frame_hold_enable;
    logic frame_priority_enable;
    logic push_page_always;
  } cfg_t;

  // one input item
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] flag_bits;
    logic        arm_hold;
    logic [15:0] mask_bits;
    logic        global_disable;
    logic        delay_pending;
    logic [8:0]  table_pointer;
    logic [15:0] stack_pointer;
    logic [15:0] program_counter;
    logic [6:0]  page_register;
    logic        dma_level;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic        taken;
    logic [3:0]  source_bit;
    logic [4:0]  vector_number;
    logic [15:0] new_pc;
    logic [15:0] new_sp;
    logic [1:0]  push_count;
    logic [15:0] pc_push_addr;
    logic [15:0] page_push_addr;
    logic [15:0] flag_value;
  } result_t;

  // block state
  typedef struct packed {
    logic [15:0] flags;
    logic        hold;
  } irq_state_t;

  // priority encoder, lowest set bit wins, 0 when empty
  function automatic logic [3:0] lowest_set(input logic [15:0] v);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/did_cfg.sv
// configuration register bank
module did_cfg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic         cfg_data,
  output did_pkg::cfg_t cfg
);

  did_pkg::cfg_t cfg_r;
  did_pkg::cfg_t cfg_nxt;

  // index decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (did_pkg::cfg_idx_t'(cfg_index))
        did_pkg::CFG_LEVEL_CHECK: cfg_nxt.level_check_enable    = cfg_data;
        did_pkg::CFG_FRAME_HOLD:  cfg_nxt.frame_hold_enable     = cfg_data;
        did_pkg::CFG_FRAME_PRIO:  cfg_nxt.frame_priority_enable = cfg_data;
        did_pkg::CFG_PUSH_PAGE:   cfg_nxt.push_page_always      = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/did_eval.sv
// single pass evaluation of one item against the flag state
module did_eval (
  input  did_pkg::cfg_t      cfg,
  input  did_pkg::in_item_t  item,
  input  did_pkg::irq_state_t st,
  output did_pkg::irq_state_t st_nxt,
  output did_pkg::result_t   res
);

  logic [15:0] flags_lvl;
  logic [15:0] pend;
  logic        dispatch;
  logic [3:0]  src;
  logic [4:0]  vec;
  logic        push_page;
  logic [15:0] sp_m1;
  logic [15:0] sp_m2;
  logic        is_check;

  assign is_check = (item.func == did_pkg::FUNC_CHECK) && cfg.level_check_enable;

  // level assertion before the pending scan
  always_comb begin
    flags_lvl = st.flags;
    if (st.hold && cfg.frame_hold_enable) flags_lvl[did_pkg::FRAME_BIT] = 1'b1;
    if (item.dma_level)                   flags_lvl[did_pkg::DMA_BIT]   = 1'b1;
  end

  assign pend = flags_lvl & item.mask_bits;

  // source select with optional frame override
  always_comb begin
    src = did_pkg::lowest_set(pend);
    if (cfg.frame_priority_enable && pend[did_pkg::FRAME_BIT])
      src = 4'(did_pkg::FRAME_BIT);
  end

  assign dispatch = is_check && !item.global_disable && !item.delay_pending &&
                    (item.table_pointer != did_pkg::TABLE_UNSET) && (pend != 16'd0);
  assign vec       = {1'b0, src} + did_pkg::VECTOR_BASE;
  assign push_page = cfg.push_page_always || (item.page_register != 7'd0);
  assign sp_m1     = item.stack_pointer - 16'd1;
  assign sp_m2     = item.stack_pointer - 16'd2;

  // state update
  always_comb begin
    st_nxt = st;
    case (item.func)
      did_pkg::FUNC_POST: begin
        st_nxt.flags = st.flags | item.flag_bits;
        if (item.arm_hold) st_nxt.hold = 1'b1;
      end
      did_pkg::FUNC_CLEAR: begin
        st_nxt.flags = st.flags & ~item.flag_bits;
      end
      did_pkg::FUNC_CHECK: begin
        if (is_check) begin
          st_nxt.flags = flags_lvl;
          if (dispatch) begin
            st_nxt.flags[src] = 1'b0;
            if (src == 4'(did_pkg::FRAME_BIT)) st_nxt.hold = 1'b0;
          end
        end
      end
      default: st_nxt = st;
    endcase
  end

  // result fields
  always_comb begin
    res                = '0;
    res.new_pc         = item.program_counter;
    res.new_sp         = item.stack_pointer;
    res.flag_value     = st_nxt.flags;
    if (dispatch) begin
      res.taken         = 1'b1;
      res.source_bit    = src;
      res.vector_number = vec;
      res.new_pc        = {item.table_pointer, 7'd0} + {9'd0, vec, 2'b00};
      res.pc_push_addr  = sp_m1;
      if (push_page) begin
        res.new_sp         = sp_m2;
        res.push_count     = 2'd2;
        res.page_push_addr = sp_m2;
      end else begin
        res.new_sp     = sp_m1;
        res.push_count = 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/dsp_interrupt_dispatch.sv
// top level of the maskable interrupt dispatch block
//
// usage:
//   input channel (in_valid / in_stall) carries one item per transfer: a check
//   at an instruction boundary, a post of flag bits or a clear of flag bits.
//   result channel (out_valid / out_stall) returns exactly one result per item,
//   in order, holding dispatch decision, stack pushes, new pc and flag value.
//   cfg_we / cfg_index / cfg_data write the four 1-bit control registers.
// timing:
//   one item per cycle sustained while out_stall stays low; an item is held in
//   the input register, passes the dispatch logic and lands in the result
//   register. the flag and hold registers update in the same cycle the item
//   moves into the result register, so the next item sees them at once.
// reset:
//   rst_n (synchronous) clears both stages, the flag register, the frame hold
//   and all control registers.
// stall:
//   while out_stall holds a full result register, the input register keeps its
//   item and in_stall rises; nothing is dropped or duplicated.
module dsp_interrupt_dispatch (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_flag_bits,
  input  logic        in_arm_hold,
  input  logic [15:0] in_mask_bits,
  input  logic        in_global_disable,
  input  logic        in_delay_pending,
  input  logic [8:0]  in_table_pointer,
  input  logic [15:0] in_stack_pointer,
  input  logic [15:0] in_program_counter,
  input  logic [6:0]  in_page_register,
  input  logic        in_dma_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_taken,
  output logic [3:0]  out_source_bit,
  output logic [4:0]  out_vector_number,
  output logic [15:0] out_new_pc,
  output logic [15:0] out_new_sp,
  output logic [1:0]  out_push_count,
  output logic [15:0] out_pc_push_addr,
  output logic [15:0] out_page_push_addr,
  output logic [15:0] out_flag_value
);

  did_pkg::cfg_t       cfg;
  did_pkg::in_item_t   item_r;
  did_pkg::in_item_t   item_in;
  logic                in_valid_r;
  logic                in_valid_nxt;
  did_pkg::irq_state_t st_r;
  did_pkg::irq_state_t st_nxt;
  did_pkg::irq_state_t st_eval;
  did_pkg::result_t    res_r;
  did_pkg::result_t    res_eval;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                advance;
  logic                accept;

  did_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  did_eval u_eval (
    .cfg    (cfg),
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_eval),
    .res    (res_eval)
  );

  // handshake control
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept)       in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance)         out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  assign st_nxt = advance ? st_eval : st_r;

  // input payload capture
  always_comb begin
    item_in.func            = in_func;
    item_in.flag_bits       = in_flag_bits;
    item_in.arm_hold        = in_arm_hold;
    item_in.mask_bits       = in_mask_bits;
    item_in.global_disable  = in_global_disable;
    item_in.delay_pending   = in_delay_pending;
    item_in.table_pointer   = in_table_pointer;
    item_in.stack_pointer   = in_stack_pointer;
    item_in.program_counter = in_program_counter;
    item_in.page_register   = in_page_register;
    item_in.dma_level       = in_dma_level;
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept)  item_r <= item_in;
    if (advance) res_r  <= res_eval;
  end

  assign out_valid          = out_valid_r;
  assign out_taken          = res_r.taken;
  assign out_source_bit     = res_r.source_bit;
  assign out_vector_number  = res_r.vector_number;
  assign out_new_pc         = res_r.new_pc;
  assign out_new_sp         = res_r.new_sp;
  assign out_push_count     = res_r.push_count;
  assign out_pc_push_addr   = res_r.pc_push_addr;
  assign out_page_push_addr = res_r.page_push_addr;
  assign out_flag_value     = res_r.flag_value;

endmodule
